// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the Annex B splitter blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("assertion failed");
// implication within the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hdl/anb_pkg.sv -----
// ---------------------------------------------------------------------------
// anb_pkg
// Shared types and constants of the Annex B start code parser.
// ---------------------------------------------------------------------------
package anb_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int EVQ_DEPTH       = 2;
  localparam int ADDR_BITS       = 3;

  localparam logic [23:0] MAX_LEN_RST = 24'd65536;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_UNIT_LENGTH = 1'b0;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_START = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [2:0] PFX_THREE = 3'd3;
  localparam logic [2:0] PFX_FOUR  = 3'd4;

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_UNIT,
    PH_SKIP
  } phase_t;

  // event from front to back
  typedef struct packed {
    logic       is_err;
    logic       fin;
    logic       ovf;
    logic       four;
    logic [7:0] hdr;
  } evt_t;

endpackage

// ----- hdl/anb_front.sv -----
// ---------------------------------------------------------------------------
// anb_front
// Byte intake: start code detection, unit byte count and event generation.
// ---------------------------------------------------------------------------
module anb_front #(
  parameter int LENGTH_BITS = anb_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_end_of_stream,
  input  logic                   q_full,
  output logic                   ev_valid,
  output anb_pkg::evt_t          ev,
  output logic [LENGTH_BITS-1:0] ev_len
);

  localparam logic [LENGTH_BITS-1:0] K3 = LENGTH_BITS'(3);
  localparam logic [LENGTH_BITS-1:0] K4 = LENGTH_BITS'(4);

  anb_pkg::phase_t        phase_r, phase_nxt;
  logic [23:0]            hist_r, hist_nxt, hist_new;
  logic [LENGTH_BITS-1:0] cnt_r, cnt_nxt, cnt_inc, len_cut, k;
  logic                   four_r, four_nxt;
  logic [7:0]             hdr_r, hdr_nxt, hdr_eff;
  logic                   seen_r, seen_nxt;
  logic                   ovf_r, ovf_nxt, ovf_new;
  logic                   accept, eos, cnt_full;
  logic [2:0]             ocnt;
  logic                   open_start, open_four, open_bad;
  logic                   hit4, hit3, hit;

  assign in_full  = q_full;
  assign accept   = in_push && !q_full;
  assign eos      = in_end_of_stream;
  assign hist_new = {hist_r[15:0], in_data_byte};
  assign ocnt     = cnt_r[2:0] + 3'd1;

  // opening check
  always_comb begin
    open_start = 1'b0;
    open_four  = 1'b0;
    open_bad   = 1'b0;
    if (ocnt == 3'd3) begin
      if (hist_new == 24'h000001) begin
        open_start = 1'b1;
      end else if (hist_new != 24'h0) begin
        open_bad = 1'b1;
      end
    end else if (ocnt >= 3'd4) begin
      if (in_data_byte == 8'h01) begin
        open_start = 1'b1;
        open_four  = 1'b1;
      end else begin
        open_bad = 1'b1;
      end
    end
  end

  // in-unit detection and counting
  assign hit4     = (hist_r == 24'h0) && (in_data_byte == 8'h01);
  assign hit3     = !hit4 && (hist_r[15:0] == 16'h0) && (in_data_byte == 8'h01);
  assign hit      = hit4 || hit3;
  assign cnt_full = &cnt_r;
  assign cnt_inc  = cnt_full ? cnt_r : cnt_r + LENGTH_BITS'(1);
  assign ovf_new  = ovf_r || cnt_full;
  assign k        = hit4 ? K4 : K3;
  assign len_cut  = (cnt_inc >= k) ? cnt_inc - k : '0;
  assign hdr_eff  = seen_r ? hdr_r : in_data_byte;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (eos) begin
        phase_nxt = anb_pkg::PH_OPEN;
      end else begin
        case (phase_r)
          anb_pkg::PH_OPEN: begin
            if (open_start) begin
              phase_nxt = anb_pkg::PH_UNIT;
            end else if (open_bad) begin
              phase_nxt = anb_pkg::PH_SKIP;
            end
          end
          anb_pkg::PH_UNIT: phase_nxt = anb_pkg::PH_UNIT;
          anb_pkg::PH_SKIP: phase_nxt = anb_pkg::PH_SKIP;
          default:          phase_nxt = anb_pkg::PH_OPEN;
        endcase
      end
    end
  end

  // stream state
  always_comb begin
    hist_nxt = hist_r;
    cnt_nxt  = cnt_r;
    four_nxt = four_r;
    hdr_nxt  = hdr_r;
    seen_nxt = seen_r;
    ovf_nxt  = ovf_r;
    if (accept) begin
      hist_nxt = hist_new;
      case (phase_r)
        anb_pkg::PH_OPEN: begin
          cnt_nxt = LENGTH_BITS'(ocnt);
          if (open_start) begin
            cnt_nxt  = open_four ? K4 : K3;
            four_nxt = open_four;
            seen_nxt = 1'b0;
            ovf_nxt  = 1'b0;
          end
        end
        anb_pkg::PH_UNIT: begin
          cnt_nxt = cnt_inc;
          ovf_nxt = ovf_new;
          if (!seen_r) begin
            hdr_nxt  = in_data_byte;
            seen_nxt = 1'b1;
          end
          if (hit) begin
            cnt_nxt  = k;
            four_nxt = hit4;
            seen_nxt = 1'b0;
            hdr_nxt  = 8'h0;
            ovf_nxt  = 1'b0;
          end
        end
        default: ;
      endcase
      if (eos) begin
        hist_nxt = 24'hFFFFFF;
        cnt_nxt  = '0;
        four_nxt = 1'b0;
        hdr_nxt  = 8'h0;
        seen_nxt = 1'b0;
        ovf_nxt  = 1'b0;
      end
    end
  end

  // event out
  always_comb begin
    ev_valid = 1'b0;
    ev       = '0;
    ev_len   = '0;
    if (accept) begin
      case (phase_r)
        anb_pkg::PH_OPEN: begin
          if (!open_start && (open_bad || eos)) begin
            ev_valid  = 1'b1;
            ev.is_err = 1'b1;
            ev.fin    = eos;
          end
        end
        anb_pkg::PH_UNIT: begin
          if (hit || eos) begin
            ev_valid = 1'b1;
            ev.fin   = eos;
            ev.four  = four_r;
            ev.hdr   = hdr_eff;
            ev.ovf   = ovf_new;
            ev_len   = hit ? len_cut : cnt_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= anb_pkg::PH_OPEN;
      hist_r  <= 24'hFFFFFF;
      cnt_r   <= '0;
      four_r  <= 1'b0;
      hdr_r   <= 8'h0;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hist_r  <= hist_nxt;
      cnt_r   <= cnt_nxt;
      four_r  <= four_nxt;
      hdr_r   <= hdr_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ----- hdl/anb_evq.sv -----
// ---------------------------------------------------------------------------
// anb_evq
// Small register queue of events between front and back.
// ---------------------------------------------------------------------------
module anb_evq #(
  parameter int WIDTH = 8,
  parameter int DEPTH = anb_pkg::EVQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic             valid,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && valid;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == LAST) ? '0 : wp_r + PW'(1);
    end
    if (do_rd) begin
      rp_nxt = (rp_r == LAST) ? '0 : rp_r + PW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/anb_back.sv -----
// ---------------------------------------------------------------------------
// anb_back
// Descriptor formatting: length saturation, header split, result register.
// ---------------------------------------------------------------------------
module anb_back #(
  parameter int LENGTH_BITS = anb_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  anb_pkg::evt_t          ev,
  input  logic [LENGTH_BITS-1:0] ev_len,
  input  logic [23:0]            lim,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [23:0]            out_unit_length,
  output logic [2:0]             out_prefix_length,
  output logic                   out_forbidden_zero,
  output logic [1:0]             out_reference_idc,
  output logic [4:0]             out_unit_type,
  output logic [1:0]             out_status,
  output logic                   out_final_unit
);

  localparam int CW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;

  logic        ov_r;
  logic        load, sat;
  logic [CW-1:0] len_ext;
  logic [23:0] len_r, len_nxt;
  logic [2:0]  pfx_r, pfx_nxt;
  logic [7:0]  hdr_r, hdr_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        fin_r;

  assign load    = q_valid && (!ov_r || out_pop);
  assign q_pop   = load;
  assign len_ext = CW'(ev_len);
  assign sat     = ev.ovf || (len_ext > CW'(lim));

  always_comb begin
    len_nxt = '0;
    pfx_nxt = '0;
    hdr_nxt = '0;
    st_nxt  = anb_pkg::ST_NO_START;
    if (!ev.is_err) begin
      pfx_nxt = ev.four ? anb_pkg::PFX_FOUR : anb_pkg::PFX_THREE;
      hdr_nxt = ev.hdr;
      st_nxt  = sat ? anb_pkg::ST_SAT : anb_pkg::ST_OK;
      len_nxt = sat ? lim : len_ext[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (load) begin
      ov_r <= 1'b1;
    end else if (out_pop) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      len_r <= len_nxt;
      pfx_r <= pfx_nxt;
      hdr_r <= hdr_nxt;
      st_r  <= st_nxt;
      fin_r <= ev.fin;
    end
  end

  assign out_empty          = !ov_r;
  assign out_unit_length    = len_r;
  assign out_prefix_length  = pfx_r;
  assign out_forbidden_zero = hdr_r[7];
  assign out_reference_idc  = hdr_r[6:5];
  assign out_unit_type      = hdr_r[4:0];
  assign out_status         = st_r;
  assign out_final_unit     = fin_r;

endmodule

// ----- hdl/annexb_nal_unit_splitter_core.sv -----
// ---------------------------------------------------------------------------
// annexb_nal_unit_splitter_core
// Annex B start code parser: one byte per item in, one unit descriptor out.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   in       | in_push / in_full  | data_byte, end_of_stream
//   out      | out_pop / out_empty| unit_length, prefix_length, header fields,
//            |                    | status, final_unit
//   cfg      | APB, pready high   | max_unit_length at byte address 0
//
// One byte item per cycle sustained while in_full is low. A descriptor travels
// from the byte that closes its unit through the event queue and then the back
// result register to the out ports. A two-entry event queue decouples
// front and back. Reset (rst_n low, synchronous) clears stream state;
// max_unit_length returns to 65536. in_full rises while the queue is full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module annexb_nal_unit_splitter_core #(
  parameter int LENGTH_BITS = anb_pkg::LENGTH_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_end_of_stream,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [23:0]                   out_unit_length,
  output logic [2:0]                    out_prefix_length,
  output logic                          out_forbidden_zero,
  output logic [1:0]                    out_reference_idc,
  output logic [4:0]                    out_unit_type,
  output logic [1:0]                    out_status,
  output logic                          out_final_unit,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [anb_pkg::ADDR_BITS-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CW = (LENGTH_BITS > 24) ? LENGTH_BITS : 24;
  localparam int QW = $bits(anb_pkg::evt_t) + LENGTH_BITS;
  localparam logic [CW-1:0] LEN_ALL = CW'({LENGTH_BITS{1'b1}});
  localparam logic [23:0] LIM_RST =
    (CW'(anb_pkg::MAX_LEN_RST) > LEN_ALL) ? LEN_ALL[23:0] : anb_pkg::MAX_LEN_RST;

  logic [23:0]            max_r, lim_r, lim_nxt;
  logic                   cfg_wr;
  logic                   fq_full, fq_valid, fq_wr, fq_pop;
  anb_pkg::evt_t          f_ev, b_ev;
  logic [LENGTH_BITS-1:0] f_len, b_len;
  logic [QW-1:0]          q_rd;

  // config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == anb_pkg::REG_MAX_UNIT_LENGTH);
  assign cfg_prdata = (cfg_paddr[2] == anb_pkg::REG_MAX_UNIT_LENGTH) ?
                      {8'h0, max_r} : 32'h0;
  assign lim_nxt    = (CW'(cfg_pwdata[23:0]) > LEN_ALL) ? LEN_ALL[23:0] : cfg_pwdata[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= anb_pkg::MAX_LEN_RST;
      lim_r <= LIM_RST;
    end else if (cfg_wr) begin
      max_r <= cfg_pwdata[23:0];
      lim_r <= lim_nxt;
    end
  end

  anb_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (fq_full),
    .ev_valid         (fq_wr),
    .ev               (f_ev),
    .ev_len           (f_len)
  );

  anb_evq #(.WIDTH(QW), .DEPTH(anb_pkg::EVQ_DEPTH)) u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_wr),
    .wr_data ({f_ev, f_len}),
    .full    (fq_full),
    .rd_en   (fq_pop),
    .valid   (fq_valid),
    .rd_data (q_rd)
  );

  assign b_ev  = anb_pkg::evt_t'(q_rd[QW-1:LENGTH_BITS]);
  assign b_len = q_rd[LENGTH_BITS-1:0];

  anb_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (fq_valid),
    .q_pop              (fq_pop),
    .ev                 (b_ev),
    .ev_len             (b_len),
    .lim                (lim_r),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_unit_length    (out_unit_length),
    .out_prefix_length  (out_prefix_length),
    .out_forbidden_zero (out_forbidden_zero),
    .out_reference_idc  (out_reference_idc),
    .out_unit_type      (out_unit_type),
    .out_status         (out_status),
    .out_final_unit     (out_final_unit)
  );

  `ASSERT_ALWAYS(a_evq_no_overrun, clk, rst_n, !(fq_wr && fq_full))
  `ASSERT_IMPLY(a_err_no_prefix, clk, rst_n, !out_empty && out_status == anb_pkg::ST_NO_START, out_prefix_length == 3'd0 && out_unit_length == 24'd0)
  `ASSERT_IMPLY(a_unit_prefix, clk, rst_n, !out_empty && out_status != anb_pkg::ST_NO_START, out_prefix_length == anb_pkg::PFX_THREE || out_prefix_length == anb_pkg::PFX_FOUR)
  `ASSERT_IMPLY(a_sat_at_limit, clk, rst_n, !out_empty && out_status == anb_pkg::ST_SAT, out_unit_length == lim_r)

endmodule

// ----- sim/tb_annexb_nal_unit_splitter_core.sv -----
// ----------------------------------------------------------------------------
// tb_annexb_nal_unit_splitter_core
// Self-checking bench for the Annex B start code parser core.
//
// Bytes go in through the push/full queue port. A behavioral splitter in the
// bench tracks the byte history and unit counters and queues the unit
// descriptor that each byte should close. Every popped descriptor is checked
// field by field against the oldest queued one. Directed streams cover the
// three- and four-byte openings, bad and short openings, trailing prefixes and
// header bytes that belong to the next start code. Random streams, mostly
// well formed with noise mixed in, then run under several max_unit_length
// settings from 0 up to all ones, with random stalls on both sides in all but one run.
// ----------------------------------------------------------------------------
module tb_annexb_nal_unit_splitter_core;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [23:0] unit_length;
    logic [2:0]  prefix_length;
    logic        forbidden_zero;
    logic [1:0]  reference_idc;
    logic [4:0]  unit_type;
    logic [1:0]  status;
    logic        final_unit;
  } unit_desc_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_stream = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [23:0] out_unit_length;
  logic [2:0]  out_prefix_length;
  logic        out_forbidden_zero;
  logic [1:0]  out_reference_idc;
  logic [4:0]  out_unit_type;
  logic [1:0]  out_status;
  logic        out_final_unit;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [anb_pkg::ADDR_BITS-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  annexb_nal_unit_splitter_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_data_byte       (in_data_byte),
    .in_end_of_stream   (in_end_of_stream),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_unit_length    (out_unit_length),
    .out_prefix_length  (out_prefix_length),
    .out_forbidden_zero (out_forbidden_zero),
    .out_reference_idc  (out_reference_idc),
    .out_unit_type      (out_unit_type),
    .out_status         (out_status),
    .out_final_unit     (out_final_unit),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #2 clk = ~clk;

  // splitter state mirrored by the bench
  logic [23:0] max_len_reg;
  logic [23:0] hist;
  logic [23:0] byte_cnt;
  logic        prefix_four;
  logic [7:0]  hdr;
  logic        hdr_seen;
  logic        len_ovf;
  anb_pkg::phase_t phase;

  unit_desc_t  expected_units[$];
  unit_desc_t  want_unit;
  logic [7:0]  stream_bytes[$];
  logic        idle_enable = 1'b1;
  int unsigned stream_items = 0;
  int unsigned units_seen = 0;
  int unsigned sat_seen = 0;
  int unsigned bad_open_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  function automatic void clear_stream();
    hist        = 24'hFFFFFF;
    byte_cnt    = '0;
    prefix_four = 1'b0;
    hdr         = '0;
    hdr_seen    = 1'b0;
    phase       = anb_pkg::PH_OPEN;
    len_ovf     = 1'b0;
  endfunction

  function automatic unit_desc_t bad_open_desc(input logic fin);
    unit_desc_t d;
    d            = '0;
    d.status     = anb_pkg::ST_NO_START;
    d.final_unit = fin;
    return d;
  endfunction

  function automatic unit_desc_t unit_desc(input logic [23:0] len, input logic fin);
    unit_desc_t d;
    d.unit_length = len;
    d.status      = anb_pkg::ST_OK;
    if (len_ovf || len > max_len_reg) begin
      d.unit_length = max_len_reg;
      d.status      = anb_pkg::ST_SAT;
    end
    d.prefix_length  = prefix_four ? anb_pkg::PFX_FOUR : anb_pkg::PFX_THREE;
    d.forbidden_zero = hdr[7];
    d.reference_idc  = hdr[6:5];
    d.unit_type      = hdr[4:0];
    d.final_unit     = fin;
    return d;
  endfunction

  // advance the mirrored splitter by one byte; returns 1 when a unit closes
  function automatic bit split_byte(input logic [7:0] b, input logic eos,
                                    output unit_desc_t d);
    logic [23:0] old_hist;
    logic [23:0] code_len;
    logic [23:0] len;
    logic        start, bad, four, three;
    old_hist = hist;
    hist     = {old_hist[15:0], b};
    d        = '0;
    if (phase == anb_pkg::PH_OPEN) begin
      start    = 1'b0;
      bad      = 1'b0;
      byte_cnt = {21'd0, byte_cnt[2:0] + 3'd1};
      if (byte_cnt == 24'd3) begin
        if (hist == 24'h000001) begin
          start       = 1'b1;
          prefix_four = 1'b0;
        end else if (hist != 24'h0) begin
          bad = 1'b1;
        end
      end else if (byte_cnt >= 24'd4) begin
        if (b == 8'h01) begin
          start       = 1'b1;
          prefix_four = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      if (start) begin
        byte_cnt = prefix_four ? 24'd4 : 24'd3;
        hdr_seen = 1'b0;
        len_ovf  = 1'b0;
        phase    = anb_pkg::PH_UNIT;
        if (eos) clear_stream();
        return 1'b0;
      end
      if (bad || eos) begin
        d = bad_open_desc(eos);
        if (eos) clear_stream();
        else phase = anb_pkg::PH_SKIP;
        return 1'b1;
      end
      return 1'b0;
    end
    if (phase == anb_pkg::PH_UNIT) begin
      four  = (old_hist == 24'h0) && (b == 8'h01);
      three = !four && (old_hist[15:0] == 16'h0) && (b == 8'h01);
      if (byte_cnt == 24'hFFFFFF) len_ovf = 1'b1;
      else byte_cnt = byte_cnt + 24'd1;
      if (!hdr_seen) begin
        hdr      = b;
        hdr_seen = 1'b1;
      end
      if (four || three) begin
        code_len = four ? 24'd4 : 24'd3;
        len      = (byte_cnt >= code_len) ? byte_cnt - code_len : 24'd0;
        d        = unit_desc(len, eos);
        if (eos) begin
          clear_stream();
        end else begin
          byte_cnt    = code_len;
          prefix_four = four;
          hdr_seen    = 1'b0;
          hdr         = '0;
          len_ovf     = 1'b0;
        end
        return 1'b1;
      end
      if (eos) begin
        d = unit_desc(byte_cnt, 1'b1);
        clear_stream();
        return 1'b1;
      end
      return 1'b0;
    end
    if (eos) clear_stream();
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 40)
      $display("MISMATCH descriptor %0d %s: got 0x%0h, want 0x%0h",
               units_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // sends one byte item; the predictor runs on the edge that accepts it
  task automatic push_byte(input logic [7:0] b, input logic eos);
    unit_desc_t d;
    @(negedge clk);
    while (idle_enable && $urandom_range(0, 99) < 10) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push          <= 1'b1;
    in_data_byte     <= b;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (phase != anb_pkg::PH_SKIP) stream_items++;
    if (split_byte(b, eos, d)) expected_units.push_back(d);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_units.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {anb_pkg::REG_MAX_UNIT_LENGTH, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    max_len_reg = value[23:0];
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic send_bytes();
    foreach (stream_bytes[i]) push_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    stream_bytes.delete();
  endtask

  task automatic send_list(input logic [7:0] list[]);
    foreach (list[i]) stream_bytes.push_back(list[i]);
    send_bytes();
  endtask

  function automatic void add_start_code();
    if ($urandom_range(0, 1)) stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'h01);
  endfunction

  function automatic logic [7:0] body_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return 8'h00;
    if (r < 36) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  // one stream: mostly well formed units, sometimes noise or a broken opening
  task automatic send_stream(input int max_units, input int max_body);
    int unsigned kind;
    int unsigned n_units;
    kind    = $urandom_range(0, 99);
    n_units = $urandom_range(1, max_units);
    if (kind < 8) begin
      repeat ($urandom_range(1, 20)) stream_bytes.push_back(body_byte());
    end else if (kind < 12) begin
      stream_bytes.push_back(8'h00);
      stream_bytes.push_back(8'h00);
      if ($urandom_range(0, 1)) stream_bytes.push_back(8'h00);
      repeat ($urandom_range(0, 6)) stream_bytes.push_back(body_byte());
    end else begin
      add_start_code();
      for (int u = 0; u < n_units; u++) begin
        stream_bytes.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, max_body)) stream_bytes.push_back(body_byte());
        if (u < n_units - 1 || $urandom_range(0, 3) == 0) add_start_code();
      end
    end
    send_bytes();
  endtask

  task automatic run_streams(input int unsigned n_items, input int max_units,
                             input int max_body);
    int unsigned first;
    first = stream_items;
    while (stream_items - first < n_items) send_stream(max_units, max_body);
  endtask

  task automatic test_opening_prefixes();
    // three-byte opening, unit closed by a four-byte code on the last byte
    send_list('{8'h00, 8'h00, 8'h01, 8'h65, 8'h00, 8'h00, 8'h00, 8'h01});
    // four-byte opening, all-ones header, then a header byte that starts the
    // next start code, then a unit closed by the end of stream
    send_list('{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h00,
                8'h00, 8'h01, 8'h80});
  endtask

  task automatic test_bad_openings();
    send_list('{8'h00, 8'h01, 8'h05, 8'h00, 8'h00, 8'h01, 8'h00});
    send_list('{8'h00, 8'h00, 8'h00, 8'h02});
    send_list('{8'h00, 8'h00});
  endtask

  task automatic test_trailing_prefix();
    send_list('{8'h00, 8'h00, 8'h01});
    send_list('{8'h00, 8'h00, 8'h00, 8'h01});
  endtask

  task automatic test_length_limit();
    write_max_length(32'd4);
    run_streams(120, 4, 8);
    write_max_length(32'hAB00_0000);
    run_streams(40, 3, 4);
    write_max_length(32'd3);
    run_streams(40, 3, 4);
    write_max_length(32'd1);
    run_streams(30, 3, 4);
    write_max_length(32'($urandom_range(20, 300)));
    run_streams(300, 2, 300);
  endtask

  task automatic test_random_streams();
    write_max_length(32'hFFFF_FFFF);
    run_streams(400, 6, 12);
    write_max_length(32'($urandom_range(5, 40)));
    idle_enable = 1'b0;
    run_streams(300, 6, 12);
    wait_idle();
    idle_enable = 1'b1;
    write_max_length(32'($urandom_range(0, 32'hFFFFFF)));
    run_streams(250, 6, 20);
    write_max_length({8'h00, anb_pkg::MAX_LEN_RST});
    run_streams(250, 5, 16);
  endtask

  always @(negedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= !(idle_enable && $urandom_range(0, 99) < 10);
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      units_seen++;
      if (out_status == anb_pkg::ST_SAT) sat_seen++;
      if (out_status == anb_pkg::ST_NO_START) bad_open_seen++;
      if (expected_units.size() == 0) begin
        report_mismatch("unexpected descriptor, unit_length", out_unit_length, 0);
      end else begin
        want_unit = expected_units.pop_front();
        check_field("unit_length", out_unit_length, want_unit.unit_length);
        check_field("prefix_length", out_prefix_length, want_unit.prefix_length);
        check_field("forbidden_zero", out_forbidden_zero, want_unit.forbidden_zero);
        check_field("reference_idc", out_reference_idc, want_unit.reference_idc);
        check_field("unit_type", out_unit_type, want_unit.unit_type);
        check_field("status", out_status, want_unit.status);
        check_field("final_unit", out_final_unit, want_unit.final_unit);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d descriptors pending", cycle_count,
               expected_units.size());
      $display("tb_annexb_nal_unit_splitter_core: done, errors");
      $finish;
    end
  end

  initial begin
    max_len_reg = anb_pkg::MAX_LEN_RST;
    clear_stream();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_opening_prefixes();
    test_bad_openings();
    test_trailing_prefix();
    test_length_limit();
    test_random_streams();
    wait_idle();
    $display("covered %0d stream bytes, %0d descriptors (%0d saturated, %0d bad openings)",
             stream_items, units_seen, sat_seen, bad_open_seen);
    $display("max_unit_length settings from 0 to all ones, %0d mismatches", error_count);
    if (error_count == 0) begin
      $display("tb_annexb_nal_unit_splitter_core: done, clean");
    end else begin
      $display("tb_annexb_nal_unit_splitter_core: done, errors");
    end
    $finish;
  end

endmodule
